// ===== hdl/sha1_hash_engine_defines.svh =====
// Assertion macros for the SHA-1 engine checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sha1_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 engine.
// No dependencies; imported by every module of the engine.
package sha1_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        last_item;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_word_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} wvars_t;

	typedef struct packed {
		logic        push;
		logic        roll;
		logic [31:0] word;
	} sched_ctl_t;

	localparam int unsigned HASH_WORDS = 5;

	localparam logic [31:0] H_INIT [HASH_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_PH0 = 32'h5a827999;
	localparam logic [31:0] K_PH1 = 32'h6ed9eba1;
	localparam logic [31:0] K_PH2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_PH3 = 32'hca62c1d6;

	localparam logic [6:0] RND_PH1    = 7'd20;
	localparam logic [6:0] RND_PH2    = 7'd40;
	localparam logic [6:0] RND_PH3    = 7'd60;
	localparam logic [6:0] RND_LAST   = 7'd79;

	localparam logic [7:0]  PAD_MARKER  = 8'h80;
	localparam logic [31:0] MARKER_WORD = {PAD_MARKER, 24'h000000};
	localparam logic [2:0]  BYTES_FULL  = 3'd4;
	localparam logic [2:0]  IDX_LAST    = 3'd4;
	localparam logic [3:0]  POS_LAST    = 4'd15;
	localparam logic [3:0]  POS_LEN_HI  = 4'd14;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	// Keeps the leading valid bytes of a short final word and appends the marker.
	function automatic logic [31:0] pad_first_word(input logic [31:0] msg,
		input logic [1:0] nb);
		logic [31:0] w;
		case (nb)
			2'd0: w = MARKER_WORD;
			2'd1: w = {msg[31:24], PAD_MARKER, 16'h0000};
			2'd2: w = {msg[31:16], PAD_MARKER, 8'h00};
			2'd3: w = {msg[31:8], PAD_MARKER};
			default: w = MARKER_WORD;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/sha1_hash_engine.sv =====
// SHA-1 engine top level: sequencer, hash state, length counter and digest output.
// A word that does not complete a block is taken while idle; the word that
// completes a 16-word block starts 80 rounds and a fold, during which no new
// word is taken, all on the single shared round unit.
// A final word adds the padding words and one or two blocks, then five
// digest words are offered one per cycle while dig_ready is high. arst_n restores the initial hash.
module sha1_hash_engine import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_word_t msg,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_word_t dig
);

	// IDLE takes message words, PAD feeds padding words into the schedule,
	// ROUND runs the 80 rounds, FOLD adds the working variables into the hash,
	// and OUT presents the five digest words.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_FOLD,
		S_OUT
	} state_t;

	// The next padding word to produce once the final message word is in.
	typedef enum logic [1:0] {
		PW_MARK,
		PW_ZERO,
		PW_LEN_LO,
		PW_DONE
	} pad_t;

	state_t      state_q;
	pad_t        pad_q;
	logic        fin_q;
	logic [3:0]  pos_q;
	logic [6:0]  rnd_q;
	logic [63:0] bitlen_q;
	logic [31:0] hash_q [HASH_WORDS];
	wvars_t      wv_q;
	wvars_t      wv_next;
	wvars_t      hash_vars;
	logic        dig_valid_q;
	dig_word_t   dig_q;

	sched_ctl_t  sched_ctl;
	logic [31:0] w_cur;
	logic        msg_acc;
	logic        dig_acc;
	logic [2:0]  nb_sat;

	assign msg_ready = (state_q == S_IDLE);
	assign msg_acc   = msg_valid && msg_ready;
	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;
	assign dig_acc   = dig_valid_q && dig_ready;

	// Byte counts above four are treated as a full word.
	assign nb_sat = (msg.valid_bytes > BYTES_FULL) ? BYTES_FULL : msg.valid_bytes;

	assign hash_vars = '{a: hash_q[0], b: hash_q[1], c: hash_q[2], d: hash_q[3],
		e: hash_q[4]};

	// One word enters the schedule per cycle while a word is accepted or padding runs, either from the input or from
	// the padding sequence; during rounds the schedule rolls instead.
	always_comb begin
		sched_ctl.push = 1'b0;
		sched_ctl.roll = (state_q == S_ROUND);
		sched_ctl.word = '0;
		if (msg_acc) begin
			sched_ctl.push = 1'b1;
			if (!msg.last_item || nb_sat == BYTES_FULL) begin
				sched_ctl.word = msg.message_word;
			end else begin
				sched_ctl.word = pad_first_word(msg.message_word, nb_sat[1:0]);
			end
		end else if (state_q == S_PAD) begin
			sched_ctl.push = 1'b1;
			case (pad_q)
				PW_MARK:   sched_ctl.word = MARKER_WORD;
				PW_ZERO:   sched_ctl.word = (pos_q == POS_LEN_HI) ? bitlen_q[63:32] : '0;
				PW_LEN_LO: sched_ctl.word = bitlen_q[31:0];
				default:   sched_ctl.word = '0;
			endcase
		end
	end

	sha1_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sha1_round u_round (
		.wv      (wv_q),
		.w       (w_cur),
		.rnd     (rnd_q),
		.wv_next (wv_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pad_q       <= PW_DONE;
			fin_q       <= 1'b0;
			pos_q       <= '0;
			rnd_q       <= '0;
			bitlen_q    <= '0;
			hash_q      <= H_INIT;
			wv_q        <= '0;
			dig_valid_q <= 1'b0;
			dig_q       <= '0;
		end else begin
			// Schedule fill position; the sixteenth word starts a block.
			if (sched_ctl.push) begin
				if (pos_q == POS_LAST) begin
					pos_q   <= '0;
					rnd_q   <= '0;
					wv_q    <= hash_vars;
					state_q <= S_ROUND;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						if (msg.last_item) begin
							bitlen_q <= bitlen_q + {58'd0, nb_sat, 3'b000};
							fin_q    <= 1'b1;
							pad_q    <= (nb_sat == BYTES_FULL) ? PW_MARK : PW_ZERO;
							if (pos_q != POS_LAST) begin
								state_q <= S_PAD;
							end
						end else begin
							bitlen_q <= bitlen_q + 64'd32;
						end
					end
				end
				S_PAD: begin
					case (pad_q)
						PW_MARK: pad_q <= PW_ZERO;
						PW_ZERO: begin
							if (pos_q == POS_LEN_HI) begin
								pad_q <= PW_LEN_LO;
							end
						end
						PW_LEN_LO: pad_q <= PW_DONE;
						default: pad_q <= PW_DONE;
					endcase
				end
				S_ROUND: begin
					wv_q <= wv_next;
					if (rnd_q == RND_LAST) begin
						rnd_q   <= '0;
						state_q <= S_FOLD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				S_FOLD: begin
					hash_q[0] <= hash_q[0] + wv_q.a;
					hash_q[1] <= hash_q[1] + wv_q.b;
					hash_q[2] <= hash_q[2] + wv_q.c;
					hash_q[3] <= hash_q[3] + wv_q.d;
					hash_q[4] <= hash_q[4] + wv_q.e;
					if (fin_q && pad_q == PW_DONE) begin
						dig_valid_q       <= 1'b1;
						dig_q.digest_word <= hash_q[0] + wv_q.a;
						dig_q.word_index  <= '0;
						dig_q.last_word   <= 1'b0;
						state_q           <= S_OUT;
					end else if (fin_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					// The hash words shift down so that the next digest word is
					// always taken from the second entry.
					if (dig_acc) begin
						if (dig_q.last_word) begin
							dig_valid_q <= 1'b0;
							hash_q      <= H_INIT;
							bitlen_q    <= '0;
							fin_q       <= 1'b0;
							pad_q       <= PW_DONE;
							state_q     <= S_IDLE;
						end else begin
							for (int i = 0; i < HASH_WORDS - 1; i++) begin
								hash_q[i] <= hash_q[i + 1];
							end
							dig_q.digest_word <= hash_q[1];
							dig_q.word_index  <= dig_q.word_index + 3'd1;
							dig_q.last_word   <= (dig_q.word_index + 3'd1 == IDX_LAST);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/sha1_sched.sv =====
// Sixteen-word message schedule held as a shift line with fixed expansion taps.
// Depends on sha1_pkg for the control struct and the rotate helper.
module sha1_sched import sha1_pkg::*; (
	input  logic       clk,
	input  sched_ctl_t ctl,
	output logic [31:0] w_cur
);

	logic [31:0] sched_q [16];
	logic [31:0] expand;

	// With the window holding W[j..j+15], this is W[j+16].
	assign expand = rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);
	assign w_cur  = sched_q[0];

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.roll) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= ctl.push ? ctl.word : expand;
		end
	end

endmodule

// ===== hdl/sha1_round.sv =====
// One SHA-1 compression round: selects f and K by round phase and updates a..e.
// Depends on sha1_pkg for the working-variable struct and constants.
module sha1_round import sha1_pkg::*; (
	input  wvars_t      wv,
	input  logic [31:0] w,
	input  logic [6:0]  rnd,
	output wvars_t      wv_next
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < RND_PH1) begin
			f = (wv.b & wv.c) | (~wv.b & wv.d);
			k = K_PH0;
		end else if (rnd < RND_PH2) begin
			f = wv.b ^ wv.c ^ wv.d;
			k = K_PH1;
		end else if (rnd < RND_PH3) begin
			f = (wv.b & wv.c) | (wv.b & wv.d) | (wv.c & wv.d);
			k = K_PH2;
		end else begin
			f = wv.b ^ wv.c ^ wv.d;
			k = K_PH3;
		end
		wv_next.a = rotl(wv.a, 5) + f + wv.e + w + k;
		wv_next.b = wv.a;
		wv_next.c = rotl(wv.b, 30);
		wv_next.d = wv.c;
		wv_next.e = wv.d;
	end

endmodule

// ===== hdl/sha1_chk.sv =====
// Port-level checker for the SHA-1 engine and the bind that attaches it.
// Depends on sha1_pkg and on the assertion macros in the defines header.
`include "sha1_hash_engine_defines.svh"

module sha1_chk import sha1_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      msg_ready,
	input logic      dig_valid,
	input logic      dig_ready,
	input dig_word_t dig
);

	logic       dig_step;
	logic       dig_wait;
	logic [2:0] idx;
	logic [2:0] idx_inc;

	// A taken digest word that is not the last one, and a stalled digest word.
	assign dig_step = dig_valid && dig_ready && !dig.last_word;
	assign dig_wait = dig_valid && !dig_ready;
	assign idx      = dig.word_index;
	assign idx_inc  = idx + 3'd1;

	// The engine never takes message words while a digest is being offered.
	`SHA1_ASSERT_NOW(a_no_overlap, dig_valid, !msg_ready, "message taken during digest")

	// A digest always starts with the first hash word.
	`SHA1_ASSERT_NOW(a_start_idx, $rose(dig_valid), idx == 3'd0, "digest does not start at H0")

	// Digest words come in order without gaps.
	`SHA1_ASSERT_NEXT(a_idx_step, dig_step, dig_valid && idx == $past(idx_inc), "index skipped")

	// The final flag marks exactly the fifth word.
	`SHA1_ASSERT_NOW(a_last_flag, dig_valid, dig.last_word == (idx == IDX_LAST), "bad last_word")

	// A stalled digest word holds steady.
	`SHA1_ASSERT_NEXT(a_dig_hold, dig_wait, dig_valid && $stable(dig), "digest changed")

endmodule

bind sha1_hash_engine sha1_chk u_sha1_chk (.*);

// ===== tb/sha1_hash_engine_test.sv =====
// Self-checking testbench for the SHA-1 engine: a queued word driver, a digest
// monitor and an in-bench SHA-1 predictor that scores every digest word.
// Depends on sha1_pkg and sha1_hash_engine from the hdl folder.
module sha1_hash_engine_test;
	import sha1_pkg::*;

	// Clock, reset and the two handshake channels. Every input of the engine
	// starts from a known value so that nothing is X when reset lets go.
	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      msg_valid = 1'b0;
	logic      msg_ready;
	msg_word_t msg = '0;
	logic      dig_valid;
	logic      dig_ready = 1'b0;
	dig_word_t dig;

	sha1_hash_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	// Message words waiting to be offered, and digest words the predictor
	// has produced but the engine has not yet delivered.
	msg_word_t words_to_send [$];
	dig_word_t digests_due [$];

	// Predictor state: running hash, the 16-word block buffer, the message
	// length in bits and how many words of the current block are filled.
	logic [31:0] hash_acc [5];
	logic [31:0] block_buf [16];
	logic [63:0] msg_bits;
	int          fill_pos;

	int   fail_count = 0;
	int   words_taken = 0;
	logic msg_taken = 1'b0;
	logic hold_off = 1'b0;
	int   send_gap = 0;
	int   send_calm = 0;
	int   recv_gap = 0;
	int   recv_calm = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Idle length for either side: mostly zero or short, now and then long,
	// and every so often a calm stretch in which no gap is inserted at all.
	function automatic int pick_gap(inout int calm_left);
		int roll;
		int len;
		roll = $urandom_range(0, 99);
		len = 0;
		if (calm_left > 0) begin
			calm_left--;
		end else if (roll < 3) begin
			calm_left = $urandom_range(20, 60);
		end else if (roll < 50) begin
			len = 0;
		end else if (roll < 82) begin
			len = $urandom_range(1, 3);
		end else if (roll < 96) begin
			len = $urandom_range(4, 10);
		end else begin
			len = $urandom_range(20, 50);
		end
		return len;
	endfunction

	task automatic clear_hash();
		for (int i = 0; i < HASH_WORDS; i++) begin
			hash_acc[i] = H_INIT[i];
		end
		msg_bits = '0;
		fill_pos = 0;
	endtask

	// One SHA-1 compression over block_buf. The working variables start from
	// the running hash on every block, and the schedule is expanded in place
	// over the 16-entry buffer from round 16 onward.
	task automatic compress_block();
		logic [31:0] a, b, c, d, e, f, k, w, t;
		a = hash_acc[0];
		b = hash_acc[1];
		c = hash_acc[2];
		d = hash_acc[3];
		e = hash_acc[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				w = block_buf[r];
			end else begin
				w = rot_left(block_buf[(r - 3) % 16] ^ block_buf[(r - 8) % 16] ^
					block_buf[(r - 14) % 16] ^ block_buf[r % 16], 1);
				block_buf[r % 16] = w;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_PH0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PH1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_PH2;
			end else begin
				f = b ^ c ^ d;
				k = K_PH3;
			end
			t = rot_left(a, 5) + f + e + w + k;
			e = d;
			d = c;
			c = rot_left(b, 30);
			b = a;
			a = t;
		end
		hash_acc[0] += a;
		hash_acc[1] += b;
		hash_acc[2] += c;
		hash_acc[3] += d;
		hash_acc[4] += e;
	endtask

	task automatic absorb_word(input logic [31:0] w);
		block_buf[fill_pos] = w;
		fill_pos++;
		if (fill_pos == 16) begin
			compress_block();
			fill_pos = 0;
		end
	endtask

	// Folds one accepted word into the predicted hash. A final word closes
	// the message: it keeps only its valid leading bytes, appends the marker
	// byte, zero fill and the 64-bit length, then queues the five digest words.
	task automatic hash_message_word(input msg_word_t it);
		int          nb;
		logic [31:0] kept;
		if (!it.last_item) begin
			// Before the end every byte counts, whatever the byte count says.
			absorb_word(it.message_word);
			msg_bits += 64'd32;
		end else begin
			// Byte counts of five and up saturate to a full word.
			nb = (it.valid_bytes > BYTES_FULL) ? 4 : int'(it.valid_bytes);
			msg_bits += 64'(nb * 8);
			if (nb == 4) begin
				absorb_word(it.message_word);
				absorb_word({PAD_MARKER, 24'h000000});
			end else begin
				kept = (nb == 0) ? 32'h0 : it.message_word & (32'hffffffff << (32 - 8 * nb));
				absorb_word(kept | ({24'h000000, PAD_MARKER} << (24 - 8 * nb)));
			end
			while (fill_pos != 14) begin
				absorb_word(32'h0);
			end
			absorb_word(msg_bits[63:32]);
			absorb_word(msg_bits[31:0]);
			for (int i = 0; i < HASH_WORDS; i++) begin
				digests_due.push_back('{digest_word: hash_acc[i], word_index: 3'(i),
					last_word: (i == HASH_WORDS - 1)});
			end
			clear_hash();
		end
	endtask

	task automatic queue_word(input logic [31:0] w, input logic [2:0] nb, input logic last);
		words_to_send.push_back('{message_word: w, valid_bytes: nb, last_item: last});
	endtask

	// Sender. Inputs change on the falling edge. A word stays on the bus until
	// the monitor has seen it taken at a rising edge; after that the next word
	// follows at once or after a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			msg_valid <= 1'b0;
		end else if (msg_valid && !msg_taken) begin
			msg_valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			msg_valid <= 1'b0;
		end else if (words_to_send.size() > 0) begin
			msg <= words_to_send.pop_front();
			msg_valid <= 1'b1;
			send_gap <= pick_gap(send_calm);
		end else begin
			msg_valid <= 1'b0;
		end
	end

	// Receiver. Ready stalls at random, and is held low throughout the
	// long hold-off so that finished digests back up into the engine.
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			dig_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			dig_ready <= 1'b0;
		end else begin
			dig_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				recv_gap <= pick_gap(recv_calm);
			end
		end
	end

	// Monitor. Everything is sampled on the rising edge: an accepted message
	// word goes to the predictor first, then an accepted digest word is
	// compared field by field with the oldest prediction.
	always @(posedge clk) begin
		dig_word_t want;
		msg_taken <= arst_n && msg_valid && msg_ready;
		if (arst_n && msg_valid && msg_ready) begin
			hash_message_word(msg);
			words_taken++;
		end
		if (arst_n && dig_valid && dig_ready) begin
			if (digests_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected digest word %h index %0d last %b",
						dig.digest_word, dig.word_index, dig.last_word);
				end
			end else begin
				want = digests_due.pop_front();
				if (dig.digest_word !== want.digest_word || dig.word_index !== want.word_index ||
					dig.last_word !== want.last_word) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
							want.digest_word, want.word_index, want.last_word,
							dig.digest_word, dig.word_index, dig.last_word);
					end
				end
			end
		end
	end

	// Backpressure: once traffic is flowing, refuse digests for a long
	// stretch while the sender keeps offering words, so the engine stalls.
	initial begin
		while (words_taken < 40) begin
			@(negedge clk);
		end
		hold_off <= 1'b1;
		repeat (500) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Timeout, several times the slowest correct run.
	initial begin
		#5000000;
		$display("sha1_hash_engine_test: errors");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		int len;
		int roll;
		clear_hash();

		// Empty message: the final word carries no bytes and only pads.
		queue_word(32'hffffffff, 3'd0, 1'b1);
		// One-word messages over every byte count; bytes past the count are
		// set so that a failure to drop them shows. Counts of five to seven
		// must act like four.
		queue_word(32'hffffffff, 3'd1, 1'b1);
		queue_word($urandom, 3'd2, 1'b1);
		queue_word(32'h61626300, 3'd3, 1'b1);
		queue_word(32'h00000000, 3'd4, 1'b1);
		queue_word($urandom, 3'd5, 1'b1);
		queue_word(32'hffffffff, 3'd6, 1'b1);
		queue_word($urandom, 3'd7, 1'b1);
		// A short byte count before the end still means a full word.
		queue_word(32'h00000000, 3'd1, 1'b0);
		queue_word(32'hffffffff, 3'd2, 1'b1);
		// Fourteen words ending in a full word: the length no longer fits,
		// so padding spills into a second block.
		for (int i = 0; i < 13; i++) begin
			queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
		end
		queue_word(32'hffffffff, 3'd4, 1'b1);

		// Random messages, mostly short, some spanning up to three blocks.
		while (words_to_send.size() < 265) begin
			roll = $urandom_range(0, 99);
			if (roll < 65) begin
				len = $urandom_range(1, 8);
			end else if (roll < 90) begin
				len = $urandom_range(9, 20);
			end else begin
				len = $urandom_range(21, 40);
			end
			for (int i = 1; i < len; i++) begin
				queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
			end
			queue_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() > 0 || msg_valid) begin
			@(posedge clk);
		end
		while (digests_due.size() > 0) begin
			@(posedge clk);
		end
		// Let any stray digest word show up before calling the run.
		repeat (250) @(posedge clk);
		if (fail_count == 0) begin
			$display("sha1_hash_engine_test: clean");
		end else begin
			$display("sha1_hash_engine_test: errors");
		end
		$finish;
	end

endmodule
